### src/cqe_pkg.sv
// Shared types and codes for the circular queue engine.
// Holds the item structs, command and status codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package cqe_pkg;

    // Command codes carried by an input item
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;

    // Status codes carried by a result item
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_DELETED  = 3'd3;
    localparam logic [2:0] ST_LISTED   = 3'd4;

    // Capacity register
    localparam int unsigned CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } cqe_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] word;
        logic               last;
    } cqe_out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DELETE,
        S_LIST
    } cqe_state_t;

endpackage

### src/circular_queue_engine_unit.sv
// Top level of the circular queue engine: slot memory, head/tail pointers and sequencer.
// Depends on cqe_pkg for item structs, command and status codes and states.
`timescale 1ns / 1ps

// Usage
// - Command channel: drive request and raise start; the item is taken at a rising edge
//   where start is high and busy is low.
// - Result channel: each result item is marked by done, which is high for a single cycle.
//   The receiver cannot stall, so results are never held back.
// - Configuration channel: cfg_data (capacity in use, 0..31, clamped to 1..DEPTH) is
//   written when cfg_valid is high; cfg_ready is always high. Write only while idle.
// Timing
// - Insert, and delete or list of an empty queue: busy stays low, so such items may
//   follow every cycle; done rises the cycle after acceptance.
// - Delete: busy for one cycle while the registered memory read of the head returns;
//   done is registered from the delete state, and a new item waits for busy to fall.
// - List of n stored words: busy while the words are read out, one result per cycle;
//   at most DEPTH results. Set by the single memory read port and the one shared
//   index-advance unit, which steps the list cursor once per cycle.
// Reset
// - Queue empty, head and tail at zero, capacity 16. Slot contents are not cleared.
module circular_queue_engine_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  cqe_pkg::cqe_in_t             request,
    output logic                         done,
    output cqe_pkg::cqe_out_t            result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [cqe_pkg::CAP_W-1:0]    cfg_data
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CMP_W = (IDX_W + 1 > cqe_pkg::CAP_W) ? IDX_W + 1 : cqe_pkg::CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_K  = IDX_W'(DEPTH - 1);

    // Registers
    cqe_pkg::cqe_state_t         state_reg, state_next;
    logic [IDX_W-1:0]            head_reg, head_next;
    logic [IDX_W-1:0]            tail_reg, tail_next;
    logic                        empty_reg, empty_next;
    logic [IDX_W-1:0]            cursor_reg, cursor_next;
    logic [IDX_W-1:0]            count_reg, count_next;
    logic [cqe_pkg::CAP_W-1:0]   cap_reg;
    cqe_pkg::cqe_out_t           result_reg, result_next;
    logic                        done_reg, done_next;
    logic signed [31:0]          rd_data_reg;

    logic signed [31:0]          slot_mem [DEPTH];

    // Combinational signals
    logic                        accept;
    logic [CMP_W-1:0]            cap_eff;
    logic [IDX_W-1:0]            adv_in;
    logic [CMP_W-1:0]            adv_sum;
    logic [IDX_W-1:0]            adv_out;
    logic                        is_full;
    logic                        list_final;
    logic [IDX_W-1:0]            rd_addr;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;

    assign accept    = start && (state_reg == cqe_pkg::S_IDLE);
    assign busy      = (state_reg != cqe_pkg::S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    // Effective capacity: zero counts as one, anything above DEPTH saturates
    always_comb
    begin
        cap_eff = CMP_W'(cap_reg);
        if (cap_eff == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        if (cap_eff > DEPTH_C)
        begin
            cap_eff = DEPTH_C;
        end
    end

    // Shared index-advance unit: tail on insert, head on delete, cursor on list
    always_comb
    begin
        unique case (state_reg)
            cqe_pkg::S_IDLE:   adv_in = tail_reg;
            cqe_pkg::S_DELETE: adv_in = head_reg;
            cqe_pkg::S_LIST:   adv_in = cursor_reg;
            default:           adv_in = tail_reg;
        endcase
        adv_sum = CMP_W'(adv_in) + CMP_W'(1);
        adv_out = (adv_sum >= cap_eff) ? '0 : adv_sum[IDX_W-1:0];
    end

    assign is_full    = !empty_reg && (adv_out == head_reg);
    assign list_final = (cursor_reg == tail_reg) || (count_reg == LAST_K);

    // Read the head while idle, the next cursor position while listing
    assign rd_addr = (state_reg == cqe_pkg::S_LIST) ? adv_out : head_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cqe_pkg::S_IDLE:
            begin
                if (accept && !empty_reg)
                begin
                    if (request.command == cqe_pkg::CMD_DELETE)
                    begin
                        state_next = cqe_pkg::S_DELETE;
                    end
                    else if (request.command == cqe_pkg::CMD_LIST)
                    begin
                        state_next = cqe_pkg::S_LIST;
                    end
                end
            end
            cqe_pkg::S_DELETE:
            begin
                state_next = cqe_pkg::S_IDLE;
            end
            cqe_pkg::S_LIST:
            begin
                if (list_final)
                begin
                    state_next = cqe_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cqe_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = empty_reg ? '0 : adv_out;
        unique case (state_reg)
            cqe_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (request.command) inside
                        cqe_pkg::CMD_INSERT:
                        begin
                            done_next        = 1'b1;
                            result_next.word = '0;
                            result_next.last = 1'b1;
                            if (is_full)
                            begin
                                result_next.status = cqe_pkg::ST_FULL;
                            end
                            else
                            begin
                                result_next.status = cqe_pkg::ST_INSERTED;
                                wr_en      = 1'b1;
                                tail_next  = wr_addr;
                                head_next  = empty_reg ? '0 : head_reg;
                                empty_next = 1'b0;
                            end
                        end
                        cqe_pkg::CMD_DELETE, cqe_pkg::CMD_LIST:
                        begin
                            // Non-empty queue: wait for the head word from memory
                            if (empty_reg)
                            begin
                                done_next          = 1'b1;
                                result_next.status = cqe_pkg::ST_EMPTY;
                                result_next.word   = '0;
                                result_next.last   = 1'b1;
                            end
                            cursor_next = head_reg;
                            count_next  = '0;
                        end
                        default:
                        begin
                            // Unused command: drop it
                        end
                    endcase
                end
            end
            cqe_pkg::S_DELETE:
            begin
                done_next          = 1'b1;
                result_next.status = cqe_pkg::ST_DELETED;
                result_next.word   = rd_data_reg;
                result_next.last   = 1'b1;
                if (head_reg == tail_reg)
                begin
                    empty_next = 1'b1;
                    head_next  = '0;
                    tail_next  = '0;
                end
                else
                begin
                    head_next = adv_out;
                end
            end
            cqe_pkg::S_LIST:
            begin
                done_next          = 1'b1;
                result_next.status = cqe_pkg::ST_LISTED;
                result_next.word   = rd_data_reg;
                result_next.last   = list_final;
                cursor_next        = adv_out;
                count_next         = count_reg + IDX_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cqe_pkg::S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            cap_reg   <= cqe_pkg::CAP_RESET;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
            done_reg  <= done_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        count_reg  <= count_next;
        result_reg <= result_next;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= request.value;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= slot_mem[rd_addr];
    end

    // Assertions
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == '0) && (tail_reg == '0))
        else $error("empty queue with pointers away from zero");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cqe_pkg::S_LIST) |-> !empty_reg)
        else $error("listing an empty queue");

    a_insert_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.command == cqe_pkg::CMD_INSERT) |=> done_reg && result_reg.last)
        else $error("insert gave no result in the next cycle");

    a_list_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cqe_pkg::S_LIST && state_next == cqe_pkg::S_IDLE)
            |=> done_reg && result_reg.last)
        else $error("listing ended without a final marked result");

    a_delete_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cqe_pkg::S_DELETE)
            |=> done_reg && (result_reg.status == cqe_pkg::ST_DELETED))
        else $error("delete gave no deleted result");

endmodule

### bench/cqe_queue_checker.sv
// Checker for the circular queue engine: mirrors the queue, predicts every result item
// and compares it with what the block emits. Depends on cqe_pkg for item structs and codes.
`timescale 1ns / 1ps

module cqe_queue_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  cqe_pkg::cqe_in_t          request,
    input  logic                      done,
    input  cqe_pkg::cqe_out_t         result,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [cqe_pkg::CAP_W-1:0] cfg_data,
    output int                        errors,
    output int                        pending,
    output int                        seen
);

    // Mirror of the queue
    logic signed [31:0]        slot_copy [DEPTH];
    logic [3:0]                head_q = '0;
    logic [3:0]                tail_q = '0;
    logic                      queue_empty = 1'b1;
    logic [cqe_pkg::CAP_W-1:0] cap_reg = cqe_pkg::CAP_RESET;

    // Results owed by the block, oldest first
    cqe_pkg::cqe_out_t awaited [$];
    cqe_pkg::cqe_out_t got_item;
    cqe_pkg::cqe_out_t want_item;

    function automatic logic [4:0] wrap_point(input logic [cqe_pkg::CAP_W-1:0] raw);
        logic [4:0] c;
        c = raw;
        if (c == 5'd0)
            c = 5'd1;
        if (c > DEPTH)
            c = 5'(DEPTH);
        return c;
    endfunction

    function automatic logic [3:0] step_index(input logic [3:0] i);
        logic [4:0] n;
        n = {1'b0, i} + 5'd1;
        return (n >= wrap_point(cap_reg)) ? 4'd0 : n[3:0];
    endfunction

    task automatic owe(input logic [2:0] st, input logic signed [31:0] w, input logic fin);
        cqe_pkg::cqe_out_t r;
        r.status = st;
        r.word   = w;
        r.last   = fin;
        awaited.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input cqe_pkg::cqe_out_t got,
                                   input cqe_pkg::cqe_out_t want);
        $display("[%0t] %s: got st=%0d word=%0d last=%0b, want st=%0d word=%0d last=%0b",
                 $time, what, got.status, got.word, got.last,
                 want.status, want.word, want.last);
        errors++;
    endtask

    // Apply one accepted command to the mirror and queue up its results
    task automatic predict_queue_op(input cqe_pkg::cqe_in_t it);
        logic [3:0] i;
        int         k;
        logic       fin;
        case (it.command)
            cqe_pkg::CMD_INSERT:
            begin
                if (!queue_empty && step_index(tail_q) == head_q)
                    owe(cqe_pkg::ST_FULL, '0, 1'b1);
                else
                begin
                    if (queue_empty)
                    begin
                        head_q      = '0;
                        tail_q      = '0;
                        queue_empty = 1'b0;
                    end
                    else
                        tail_q = step_index(tail_q);
                    slot_copy[tail_q] = it.value;
                    owe(cqe_pkg::ST_INSERTED, '0, 1'b1);
                end
            end
            cqe_pkg::CMD_DELETE:
            begin
                if (queue_empty)
                    owe(cqe_pkg::ST_EMPTY, '0, 1'b1);
                else
                begin
                    owe(cqe_pkg::ST_DELETED, slot_copy[head_q], 1'b1);
                    if (head_q == tail_q)
                    begin
                        queue_empty = 1'b1;
                        head_q      = '0;
                        tail_q      = '0;
                    end
                    else
                        head_q = step_index(head_q);
                end
            end
            cqe_pkg::CMD_LIST:
            begin
                if (queue_empty)
                    owe(cqe_pkg::ST_EMPTY, '0, 1'b1);
                else
                begin
                    i   = head_q;
                    k   = 0;
                    fin = 1'b0;
                    while (!fin)
                    begin
                        fin = (i == tail_q) || (k + 1 >= DEPTH);
                        owe(cqe_pkg::ST_LISTED, slot_copy[i], fin);
                        k++;
                        i = step_index(i);
                    end
                end
            end
            default:
            begin
                // command three: no result, no change
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_q      = '0;
            tail_q      = '0;
            queue_empty = 1'b1;
            cap_reg     = cqe_pkg::CAP_RESET;
            awaited.delete();
            pending     = 0;
        end
        else
        begin
            if (done)
            begin
                got_item = result;
                if (awaited.size() == 0)
                    report_mismatch("result with nothing awaited", got_item, '0);
                else
                begin
                    want_item = awaited.pop_front();
                    if (got_item.status !== want_item.status
                        || got_item.word !== want_item.word
                        || got_item.last !== want_item.last)
                        report_mismatch("result differs", got_item, want_item);
                end
                seen++;
            end
            // An item taken at this edge still sees the old capacity
            if (start && !busy)
                predict_queue_op(request);
            if (cfg_valid && cfg_ready)
                cap_reg = cfg_data;
            pending = awaited.size();
        end
    end

endmodule

### bench/circular_queue_engine_unit_tb.sv
// Testbench top for circular_queue_engine_unit: clock, reset, command and capacity stimulus.
// Depends on cqe_pkg, the block itself and cqe_queue_checker, which does all the checking.
`timescale 1ns / 1ps

module circular_queue_engine_unit_tb;

    localparam int unsigned DEPTH        = 16;
    localparam logic [1:0]  CMD_IGNORED  = 2'd3;   // command three: no result expected
    localparam int          QUIET_LIMIT  = 2000;   // cycles with no handshake before giving up
    localparam int          SEGMENT_SIZE = 72;     // counted items per random segment

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    cqe_pkg::cqe_in_t          request = '0;
    logic                      done;
    cqe_pkg::cqe_out_t         result;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [cqe_pkg::CAP_W-1:0] cfg_data = cqe_pkg::CAP_RESET;

    int    errors;
    int    pending;
    int    seen;
    int    idle_pct = 8;
    int    quiet = 0;
    int    n_insert = 0;
    int    n_delete = 0;
    int    n_list = 0;
    int    n_ignored = 0;
    string caps_used = "";

    logic [cqe_pkg::CAP_W-1:0] seg_caps [6];

    // 8 ns period: high for 4, low for 4
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    circular_queue_engine_unit #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    cqe_queue_checker #(.DEPTH(DEPTH)) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .seen      (seen)
    );

    // Watchdog: count cycles in which no item, result or register write moves, and
    // abandon the run once the count reaches the limit.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Mostly random words, with the extremes of the signed range mixed in
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Offer one item and hold it until the block takes it. Start stays high after the
    // handshake so that the next item can follow in the very next cycle; idle cycles
    // are inserted before the item at the current idle rate.
    task automatic issue(input logic [1:0] cmd, input logic signed [31:0] val);
        cqe_pkg::cqe_in_t it;
        it.command = cmd;
        it.value   = val;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (cmd)
            cqe_pkg::CMD_INSERT: n_insert++;
            cqe_pkg::CMD_DELETE: n_delete++;
            cqe_pkg::CMD_LIST:   n_list++;
            default:             n_ignored++;
        endcase
    endtask

    // Drop start and hold off until every owed result has come back. Sample on the falling
    // edge so the count is never read while the checker updates it.
    task automatic settle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write the capacity register through its valid/ready channel
    task automatic write_capacity(input logic [cqe_pkg::CAP_W-1:0] c);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        caps_used = {caps_used, $sformatf(" %0d", c)};
    endtask

    // Random traffic in runs that lean towards filling, draining or neither, so the
    // queue regularly reaches both full and empty at whatever capacity is set.
    task automatic random_segment(input int count);
        int         n;
        int         mode;
        int         r;
        logic [1:0] cmd;
        n    = 0;
        mode = $urandom_range(2);
        while (n < count)
        begin
            if ($urandom_range(19) == 0)
                mode = $urandom_range(2);
            r = $urandom_range(99);
            if (r < 3)
                cmd = CMD_IGNORED;
            else if (r < 16)
                cmd = cqe_pkg::CMD_LIST;
            else
            begin
                r = $urandom_range(99);
                case (mode)
                    0:       cmd = (r < 70) ? cqe_pkg::CMD_INSERT : cqe_pkg::CMD_DELETE;
                    1:       cmd = (r < 35) ? cqe_pkg::CMD_INSERT : cqe_pkg::CMD_DELETE;
                    default: cmd = (r < 55) ? cqe_pkg::CMD_INSERT : cqe_pkg::CMD_DELETE;
                endcase
            end
            issue(cmd, pick_word());
            if (cmd != CMD_IGNORED)
                n++;
        end
    endtask

    initial
    begin
        // Capacity per random segment: smallest, zero (taken as one), above range
        // (saturates), full depth, then two random settings.
        seg_caps[0] = 5'd1;
        seg_caps[1] = 5'd0;
        seg_caps[2] = 5'd31;
        seg_caps[3] = 5'd16;
        seg_caps[4] = 5'($urandom_range(2, 15));
        seg_caps[5] = 5'($urandom_range(0, 31));

        // Hold reset, then release it on a rising edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at full capacity
        write_capacity(cqe_pkg::CAP_RESET);
        issue(cqe_pkg::CMD_LIST, pick_word());     // list of an empty queue
        issue(cqe_pkg::CMD_DELETE, pick_word());   // delete from an empty queue
        issue(CMD_IGNORED, -32'sd1);               // command three is ignored
        // Fill every slot once, so no later read can touch an unwritten slot,
        // whatever the capacity becomes
        for (int j = 0; j < DEPTH; j++)
        begin
            case (j)
                0:       issue(cqe_pkg::CMD_INSERT, 32'sh8000_0000);
                1:       issue(cqe_pkg::CMD_INSERT, 32'sh7FFF_FFFF);
                2:       issue(cqe_pkg::CMD_INSERT, 32'sh0000_0000);
                3:       issue(cqe_pkg::CMD_INSERT, -32'sd1);
                default: issue(cqe_pkg::CMD_INSERT, $urandom);
            endcase
        end
        issue(cqe_pkg::CMD_INSERT, pick_word());   // full
        issue(cqe_pkg::CMD_LIST, pick_word());     // longest listing, last on the sixteenth
        issue(cqe_pkg::CMD_DELETE, pick_word());
        issue(cqe_pkg::CMD_DELETE, pick_word());
        issue(cqe_pkg::CMD_INSERT, pick_word());   // tail wraps to slot 0
        issue(cqe_pkg::CMD_INSERT, pick_word());
        issue(cqe_pkg::CMD_INSERT, pick_word());   // full again, across the wrap

        // Random segments. Each capacity change lands on an idle block, mostly with a
        // non-empty queue, so indices beyond the new wrap point get exercised.
        // Sender idle chance: 8 percent for the first two, 49 for the next two, then none.
        for (int s = 0; s < 6; s++)
        begin
            settle();
            write_capacity(seg_caps[s]);
            idle_pct = (s < 2) ? 8 : (s < 4) ? 49 : 0;
            random_segment(SEGMENT_SIZE);
        end

        // Drain, then give the block time to show any stray result
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);

        $display("covered %0d insert, %0d delete, %0d list and %0d ignored commands, %0d results",
                 n_insert, n_delete, n_list, n_ignored, seen);
        $display("capacity settings written:%s", caps_used);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
